// ===== rtl/spmv_pkg.sv =====
package spmv_pkg;

  localparam int MaxSize   = 1024;
  localparam int IdxW      = $clog2(MaxSize);
  localparam int SizeW     = IdxW + 1;
  localparam int LinkDepth = 4;
  localparam int LinkPtrW  = $clog2(LinkDepth);
  localparam int LinkCntW  = LinkPtrW + 1;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(MaxSize);
  localparam logic [1:0]       AddrMatrixSize = 2'd0;

  localparam logic [63:0] FpDefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FpPosZero    = 64'h0;

  typedef struct packed {
    logic        func;
    logic [63:0] operand_bits;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] row_number;
    logic [63:0]     sum_bits;
    logic            final_row;
  } out_item_t;

  // one matrix element with its vector operand, as handed to the back end
  typedef struct packed {
    logic [63:0]     operand;
    logic [63:0]     vec;
    logic            skip;
    logic            eor;
    logic [IdxW-1:0] row;
    logic            last;
  } link_entry_t;

  // Round a normalized magnitude to double, round to nearest even.
  // value = m / 2^63 * 2^(eb - 1023), m[63] set; sticky_in holds bits below m.
  function automatic logic [63:0] fp_round(input logic sign,
                                           input logic signed [13:0] eb,
                                           input logic [63:0] m,
                                           input logic sticky_in);
    logic [6:0]  sh;
    logic [63:0] mm;
    logic        st;
    logic [10:0] ex;
    logic [62:0] base;
    logic        inc;
    logic [63:0] res;
    sh = 7'd0;
    mm = m;
    st = sticky_in;
    ex = 11'd0;
    if (eb >= 14'sd2047) begin
      res = {sign, 11'h7FF, 52'd0};
    end else begin
      if (eb <= 14'sd0) begin
        // subnormal: shift down to the minimum exponent
        sh = (eb < -14'sd62) ? 7'd64 : 7'(14'sd1 - eb);
        mm = m >> sh;
        st = sticky_in | (|(m & ((64'h1 << sh) - 64'h1)));
        ex = 11'd0;
      end else begin
        ex = eb[10:0];
      end
      base = {ex, mm[62:11]};
      inc  = mm[10] & (st | (|mm[9:0]) | mm[11]);
      res  = {sign, base + 63'(inc)};
    end
    return res;
  endfunction

endpackage

// ===== rtl/spmv_link.sv =====
module spmv_link (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  spmv_pkg::link_entry_t       entry_i,
  input  logic                        pop_i,
  output spmv_pkg::link_entry_t       entry_o,
  output logic                        empty_o,
  output logic [spmv_pkg::LinkCntW-1:0] count_o
);
  import spmv_pkg::*;

  link_entry_t         mem_q [LinkDepth];
  logic [LinkPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [LinkCntW-1:0] cnt_q, cnt_d;
  logic                do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign entry_o = mem_q[rd_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = push_i ? wr_q + LinkPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + LinkPtrW'(1) : rd_q;
    cnt_d = cnt_q + LinkCntW'(push_i) - LinkCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/spmv_front.sv =====
module spmv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [spmv_pkg::SizeW-1:0]    size_i,
  input  logic                          push,
  output logic                          full,
  input  spmv_pkg::in_item_t            in_i,
  input  logic [spmv_pkg::LinkCntW-1:0] link_cnt_i,
  output logic                          link_push_o,
  output spmv_pkg::link_entry_t         link_entry_o
);
  import spmv_pkg::*;

  logic [63:0]     vec_mem [MaxSize];
  logic [63:0]     vec_rd_q;
  logic [SizeW-1:0] n;
  logic            accept, acc_vec, acc_mat;
  logic [IdxW-1:0] fill_q, fill_d, col_q, col_d, row_q, row_d;
  logic [SizeW-1:0] fill_inc, col_inc, row_inc;
  logic            eor, last;
  logic            s1_valid_q;
  logic [63:0]     s1_op_q;
  logic            s1_eor_q, s1_last_q;
  logic [IdxW-1:0] s1_row_q;
  logic [LinkCntW:0] used;

  always_comb begin
    if (size_i == '0) begin
      n = SizeW'(1);
    end else if (size_i > SizeW'(MaxSize)) begin
      n = SizeW'(MaxSize);
    end else begin
      n = size_i;
    end
  end

  // credit for the element still in the read stage
  assign used    = {1'b0, link_cnt_i} + (LinkCntW + 1)'(s1_valid_q);
  assign full    = (used >= (LinkCntW + 1)'(LinkDepth));
  assign accept  = push & ~full;
  assign acc_vec = accept & ~in_i.func;
  assign acc_mat = accept & in_i.func;

  always_comb begin
    fill_inc = {1'b0, fill_q} + SizeW'(1);
    col_inc  = {1'b0, col_q} + SizeW'(1);
    row_inc  = {1'b0, row_q} + SizeW'(1);
    eor      = (col_inc >= n);
    last     = (row_inc >= n);
    fill_d   = fill_q;
    col_d    = col_q;
    row_d    = row_q;
    if (acc_vec) begin
      fill_d = (fill_inc >= n) ? '0 : fill_inc[IdxW-1:0];
    end
    if (acc_mat) begin
      col_d = eor ? '0 : col_inc[IdxW-1:0];
      if (eor) begin
        row_d = last ? '0 : row_inc[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= acc_mat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_mat) begin
      s1_op_q   <= in_i.operand_bits;
      s1_eor_q  <= eor;
      s1_last_q <= last;
      s1_row_q  <= row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_vec) begin
      vec_mem[fill_q] <= in_i.operand_bits;
    end
    if (acc_mat) begin
      vec_rd_q <= vec_mem[col_q];
    end
  end

  assign link_push_o = s1_valid_q;
  always_comb begin
    link_entry_o.operand = s1_op_q;
    link_entry_o.vec     = vec_rd_q;
    link_entry_o.skip    = (s1_op_q[62:0] == 63'd0);
    link_entry_o.eor     = s1_eor_q;
    link_entry_o.row     = s1_row_q;
    link_entry_o.last    = s1_last_q;
  end

endmodule

// ===== rtl/spmv_back.sv =====
module spmv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  link_empty_i,
  input  spmv_pkg::link_entry_t link_entry_i,
  output logic                  link_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output spmv_pkg::out_item_t   out_o
);
  import spmv_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul0 = 4'd1;
  localparam logic [3:0] StMul1 = 4'd2;
  localparam logic [3:0] StMul2 = 4'd3;
  localparam logic [3:0] StMul3 = 4'd4;
  localparam logic [3:0] StRndM = 4'd5;
  localparam logic [3:0] StAdd0 = 4'd6;
  localparam logic [3:0] StAdd1 = 4'd7;
  localparam logic [3:0] StAdd2 = 4'd8;
  localparam logic [3:0] StRndA = 4'd9;
  localparam logic [3:0] StEmit = 4'd10;

  function automatic logic [5:0] lzc53(input logic [52:0] m);
    logic [5:0] c;
    c = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (m[i]) c = 6'(52 - i);
    end
    return c;
  endfunction

  function automatic logic [6:0] lzc65(input logic [64:0] m);
    logic [6:0] c;
    c = 7'd0;
    for (int i = 0; i < 65; i++) begin
      if (m[i]) c = 7'(64 - i);
    end
    return c;
  endfunction

  logic [3:0]   st_q, st_d;
  link_entry_t  cur_q;
  logic [63:0]  acc_q, prod_q;
  logic         sp_q;
  logic [63:0]  spv_q;
  logic         sgn_q;
  logic signed [13:0] ep_q;
  logic [52:0]  man_q, mbn_q;
  logic [53:0]  pp0_q, pp1_q, pp2_q, pp3_q;
  logic [105:0] p_q;
  logic [63:0]  mb_q, ms_q;
  logic         sub_q;
  logic [64:0]  s_q;
  logic         r_sign_q;
  logic signed [13:0] r_eb_q;
  logic [63:0]  r_m_q;
  logic         r_st_q;
  logic [63:0]  rnd_res;

  // result queue
  out_item_t    oq_q [2];
  logic         owr_q, ord_q;
  logic [1:0]   ocnt_q;
  logic         opush, opop;

  assign rnd_res    = fp_round(r_sign_q, r_eb_q, r_m_q, r_st_q);
  assign link_pop_o = (st_q == StIdle) & ~link_empty_i;
  assign empty      = (ocnt_q == 2'd0);
  assign out_o      = oq_q[ord_q];
  assign opop       = pop & ~empty;
  assign opush      = (st_q == StEmit) & cur_q.eor & (ocnt_q != 2'd2);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (!link_empty_i) st_d = link_entry_i.skip ? StEmit : StMul0;
      StMul0: st_d = StMul1;
      StMul1: st_d = StMul2;
      StMul2: st_d = StMul3;
      StMul3: st_d = StRndM;
      StRndM: st_d = StAdd0;
      StAdd0: st_d = StAdd1;
      StAdd1: st_d = StAdd2;
      StAdd2: st_d = StRndA;
      StRndA: st_d = StEmit;
      StEmit: if (!cur_q.eor || ocnt_q != 2'd2) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      acc_q  <= FpPosZero;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (st_q == StRndA) begin
        acc_q <= sp_q ? spv_q : rnd_res;
      end else if (opush) begin
        acc_q <= FpPosZero;
      end
      if (opush) owr_q <= ~owr_q;
      if (opop)  ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owr_q].row_number <= cur_q.row;
      oq_q[owr_q].sum_bits   <= acc_q;
      oq_q[owr_q].final_row  <= cur_q.last;
    end
  end

  // datapath: one step of multiply or add per cycle
  always_ff @(posedge clk_i) begin : dp
    logic [63:0] a, b, x, y, big, sml, msf, mss;
    logic [10:0] ea, eb2, ex, ey;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [52:0] ma, mb;
    logic [5:0]  lza, lzb;
    logic signed [13:0] ea_s, eb_s, eg, es, dif;
    logic [6:0]  d, lz;
    logic [54:0] mid;
    logic [107:0] t;
    logic [64:0] sn;
    a = cur_q.operand;
    b = cur_q.vec;
    x = acc_q;
    y = prod_q;
    big = 64'd0; sml = 64'd0; msf = 64'd0; mss = 64'd0;
    ea = a[62:52]; eb2 = b[62:52]; ex = x[62:52]; ey = y[62:52];
    a_nan  = (ea == 11'h7FF) & (a[51:0] != 52'd0);
    b_nan  = (eb2 == 11'h7FF) & (b[51:0] != 52'd0);
    a_inf  = (ea == 11'h7FF) & (a[51:0] == 52'd0);
    b_inf  = (eb2 == 11'h7FF) & (b[51:0] == 52'd0);
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    x_nan  = (ex == 11'h7FF) & (x[51:0] != 52'd0);
    y_nan  = (ey == 11'h7FF) & (y[51:0] != 52'd0);
    x_inf  = (ex == 11'h7FF) & (x[51:0] == 52'd0);
    y_inf  = (ey == 11'h7FF) & (y[51:0] == 52'd0);
    x_zero = (x[62:0] == 63'd0);
    y_zero = (y[62:0] == 63'd0);
    ma = {ea != 11'd0, a[51:0]};
    mb = {eb2 != 11'd0, b[51:0]};
    lza = lzc53(ma);
    lzb = lzc53(mb);
    ea_s = (ea == 11'd0) ? 14'sd1 : $signed({3'b0, ea});
    eb_s = (eb2 == 11'd0) ? 14'sd1 : $signed({3'b0, eb2});
    eg = 14'sd0; es = 14'sd0; dif = 14'sd0; d = 7'd0;
    mid = 55'({1'b0, pp1_q}) + 55'({1'b0, pp2_q});
    t   = {pp3_q, 54'd0} + {26'd0, mid, 27'd0} + {54'd0, pp0_q};
    lz  = lzc65(s_q);
    sn  = s_q << lz;

    if (st_q == StIdle && !link_empty_i) begin
      cur_q <= link_entry_i;
    end

    unique case (st_q)
      StMul0: begin
        sgn_q <= a[63] ^ b[63];
        man_q <= ma << lza;
        mbn_q <= mb << lzb;
        ep_q  <= ea_s + eb_s - $signed({8'd0, lza}) - $signed({8'd0, lzb});
        sp_q  <= 1'b1;
        if (a_nan) begin
          spv_q <= a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
          spv_q <= b | 64'h0008_0000_0000_0000;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
          spv_q <= FpDefaultNan;
        end else if (a_inf || b_inf) begin
          spv_q <= {a[63] ^ b[63], 11'h7FF, 52'd0};
        end else if (a_zero || b_zero) begin
          spv_q <= {a[63] ^ b[63], 63'd0};
        end else begin
          sp_q  <= 1'b0;
          spv_q <= FpPosZero;
        end
      end
      StMul1: begin
        pp0_q <= 54'(man_q[26:0]) * 54'(mbn_q[26:0]);
        pp1_q <= 54'(man_q[26:0]) * 54'(mbn_q[52:27]);
        pp2_q <= 54'(man_q[52:27]) * 54'(mbn_q[26:0]);
        pp3_q <= 54'(man_q[52:27]) * 54'(mbn_q[52:27]);
      end
      StMul2: p_q <= t[105:0];
      StMul3: begin
        r_sign_q <= sgn_q;
        if (p_q[105]) begin
          r_m_q  <= p_q[105:42];
          r_st_q <= |p_q[41:0];
          r_eb_q <= ep_q - 14'sd1022;
        end else begin
          r_m_q  <= p_q[104:41];
          r_st_q <= |p_q[40:0];
          r_eb_q <= ep_q - 14'sd1023;
        end
      end
      StRndM: prod_q <= sp_q ? spv_q : rnd_res;
      StAdd0: begin
        // larger magnitude first; bit patterns order like magnitudes
        if (x[62:0] >= y[62:0]) begin
          big = x; sml = y;
        end else begin
          big = y; sml = x;
        end
        eg  = (big[62:52] == 11'd0) ? 14'sd1 : $signed({3'b0, big[62:52]});
        es  = (sml[62:52] == 11'd0) ? 14'sd1 : $signed({3'b0, sml[62:52]});
        dif = eg - es;
        d   = (dif > 14'sd64) ? 7'd64 : dif[6:0];
        msf = {sml[62:52] != 11'd0, sml[51:0], 11'd0};
        mss = msf >> d;
        mb_q  <= {big[62:52] != 11'd0, big[51:0], 11'd0};
        ms_q  <= mss | 64'(|(msf & ((64'h1 << d) - 64'h1)));
        ep_q  <= eg;
        sgn_q <= big[63];
        sub_q <= x[63] ^ y[63];
        sp_q  <= 1'b1;
        if (x_nan) begin
          spv_q <= x | 64'h0008_0000_0000_0000;
        end else if (y_nan) begin
          spv_q <= y | 64'h0008_0000_0000_0000;
        end else if (x_inf && y_inf && (x[63] != y[63])) begin
          spv_q <= FpDefaultNan;
        end else if (x_inf) begin
          spv_q <= x;
        end else if (y_inf) begin
          spv_q <= y;
        end else if (x_zero && y_zero) begin
          spv_q <= {x[63] & y[63], 63'd0};
        end else if (x_zero) begin
          spv_q <= y;
        end else if (y_zero) begin
          spv_q <= x;
        end else begin
          sp_q  <= 1'b0;
          spv_q <= FpPosZero;
        end
      end
      StAdd1: s_q <= sub_q ? ({1'b0, mb_q} - {1'b0, ms_q}) : ({1'b0, mb_q} + {1'b0, ms_q});
      StAdd2: begin
        // exact cancellation gives +0
        if (!sp_q && s_q == 65'd0) begin
          sp_q  <= 1'b1;
          spv_q <= FpPosZero;
        end
        r_sign_q <= sgn_q;
        r_m_q    <= sn[64:1];
        r_st_q   <= sn[0];
        r_eb_q   <= ep_q + 14'sd1 - $signed({7'd0, lz});
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sparse_matrix_vector_multiply_unit.sv =====
// The back end pops a matrix element from the link queue when it is idle; a nonzero
// element then passes pop, multiply, round, add, round and emit in that order, a zero
// element goes straight from pop to emit, and emit waits while the result queue is full
// at a row end. The serial multiply-add sequencer takes no new element until it is done
// with the last one; vector loads stay in the front end and wait only on full.
// Reset (async, active low) clears counters, queues and the sum; matrix_size = 1024.
module sparse_matrix_vector_multiply_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  spmv_pkg::in_item_t  in_i,
  output logic                empty,
  input  logic                pop,
  output spmv_pkg::out_item_t out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import spmv_pkg::*;

  logic [SizeW-1:0]    size_q;
  logic                link_push, link_pop, link_empty;
  link_entry_t         link_in, link_out;
  logic [LinkCntW-1:0] link_cnt;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrMatrixSize) ? 32'(size_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (psel && penable && pwrite && pready && paddr == AddrMatrixSize) begin
      size_q <= pwdata[SizeW-1:0];
    end
  end

  spmv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (size_q),
    .push         (push),
    .full         (full),
    .in_i         (in_i),
    .link_cnt_i   (link_cnt),
    .link_push_o  (link_push),
    .link_entry_o (link_in)
  );

  spmv_link u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (link_push),
    .entry_i (link_in),
    .pop_i   (link_pop),
    .entry_o (link_out),
    .empty_o (link_empty),
    .count_o (link_cnt)
  );

  spmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_empty_i (link_empty),
    .link_entry_i (link_out),
    .link_pop_o   (link_pop),
    .empty        (empty),
    .pop          (pop),
    .out_o        (out_o)
  );

endmodule

// ===== rtl/spmv_checker.sv =====
module spmv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input spmv_pkg::out_item_t out_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [1:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);
  import spmv_pkg::*;

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == AddrMatrixSize) |=>
      (paddr != AddrMatrixSize) || (prdata == 32'($past(pwdata[SizeW-1:0]))))
    else $error("matrix_size readback mismatch");

  a_reset_state: assert property (@(posedge clk_i) $rose(rst_ni) |-> (empty && !full))
    else $error("queues not clear after reset");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed");

endmodule

bind sparse_matrix_vector_multiply_unit spmv_checker u_spmv_checker (.*);

// ===== verif/sparse_matrix_vector_multiply_unit_tb.sv =====
`timescale 1ns / 1ps

module sparse_matrix_vector_multiply_unit_tb;
  import spmv_pkg::*;

  localparam int CycleLimit = 100000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sparse_matrix_vector_multiply_unit u_top (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [63:0]      vec_mem [MaxSize];
  bit               vec_written [MaxSize];
  int unsigned      fill_cnt, row_cnt, col_cnt, size_reg;
  logic [63:0]      acc_sum;

  in_item_t  pend_items[$];
  out_item_t row_sums[$];

  int  errors = 0;
  int  mismatches = 0;
  bit  quiet = 1'b0;
  bit  tx_done = 1'b0;
  int  hold_req = 0;
  int  hold_cnt = 0;
  int  cycles = 0;

  function automatic int unsigned eff_size();
    if (size_reg < 1) return 1;
    if (size_reg > MaxSize) return MaxSize;
    return size_reg;
  endfunction

  // advance the predictor by one queued item
  task automatic predict(input in_item_t it);
    int unsigned n;
    real         p, s;
    out_item_t   r;
    n = eff_size();
    if (!it.func) begin
      if (fill_cnt < MaxSize) begin
        vec_mem[fill_cnt] = it.operand_bits;
        vec_written[fill_cnt] = 1'b1;
      end
      fill_cnt++;
      if (fill_cnt >= n) fill_cnt = 0;
    end else begin
      if (it.operand_bits[62:0] != '0) begin
        p = $bitstoreal(it.operand_bits) * $bitstoreal(vec_mem[col_cnt]);
        s = $bitstoreal(acc_sum) + p;
        acc_sum = $realtobits(s);
      end
      col_cnt++;
      if (col_cnt >= n) begin
        col_cnt = 0;
        r.row_number = row_cnt[IdxW-1:0];
        r.sum_bits = acc_sum;
        r.final_row = (row_cnt + 1 >= n);
        row_sums.push_back(r);
        acc_sum = FpPosZero;
        row_cnt = r.final_row ? 0 : row_cnt + 1;
      end
    end
  endtask

  function automatic logic [63:0] rand_fp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1: ;
      2: begin
        case ($urandom_range(8))
          0: v = 64'h0;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7FF0_0000_0000_0000;
          3: v = 64'hFFF0_0000_0000_0000;
          4: v = 64'h7FF8_0000_0000_0000;
          5: v = 64'h0000_0000_0000_0001;
          6: v = 64'h7FEF_FFFF_FFFF_FFFF;
          7: v = 64'h000F_FFFF_FFFF_FFFF;
          default: v = 64'h3FF0_0000_0000_0000;
        endcase
      end
      3: v[62:52] = 11'($urandom_range(1, 40));  // deep subnormal products
      default: v[62:52] = 11'($urandom_range(1003, 1043));
    endcase
    return v;
  endfunction

  task automatic send(input logic f, input logic [63:0] bits);
    in_item_t it;
    it.func = f;
    it.operand_bits = bits;
    // never let a nonzero element read an unwritten vector entry
    if (f && !vec_written[col_cnt]) it.operand_bits[62:0] = '0;
    predict(it);
    pend_items.push_back(it);
  endtask

  task automatic send_mat(input int pct_nz);
    logic [63:0] v;
    v = rand_fp();
    if ($urandom_range(99) >= pct_nz) v[62:0] = '0;
    send(1'b1, v);
  endtask

  task automatic load_vector();
    int unsigned n;
    n = eff_size();
    for (int i = 0; i < n; i++) send(1'b0, rand_fp());
  endtask

  task automatic drain();
    while (pend_items.size() != 0 || row_sums.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);  // trailing mid-row elements may still be in flight
  endtask

  task automatic reg_write(input logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrMatrixSize; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (rd[SizeW-1:0] != val[SizeW-1:0]) begin
      errors++;
      $display("matrix_size readback: expected %0d got %0d", val[SizeW-1:0], rd[SizeW-1:0]);
    end
    size_reg = val[SizeW-1:0];
  endtask

  // sample input transfers
  always @(posedge clk_i) tx_done <= push & ~full;

  // driver
  always @(negedge clk_i) begin
    if (tx_done) void'(pend_items.pop_front());
    if (pend_items.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
      push <= 1'b1;
      in_i <= pend_items[0];
    end else begin
      push <= 1'b0;
    end
  end

  // receiver hold-off counter
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt <= hold_req;
      hold_req <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(negedge clk_i)
    pop <= (hold_cnt == 0) && (quiet || $urandom_range(99) >= 17);

  // monitor
  always @(posedge clk_i) begin
    out_item_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && pop && !empty) begin
      if (row_sums.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row result row=%0d sum=%h", out_o.row_number, out_o.sum_bits);
      end else begin
        e = row_sums.pop_front();
        if (out_o.row_number !== e.row_number || out_o.sum_bits !== e.sum_bits ||
            out_o.final_row !== e.final_row) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected row=%0d sum=%h last=%b, got row=%0d sum=%h last=%b",
                     e.row_number, e.sum_bits, e.final_row,
                     out_o.row_number, out_o.sum_bits, out_o.final_row);
        end
      end
    end
  end

  initial begin
    int n, rows;
    fill_cnt = 0; row_cnt = 0; col_cnt = 0; acc_sum = FpPosZero; size_reg = MaxSize;
    for (int i = 0; i < MaxSize; i++) begin
      vec_mem[i] = '0;
      vec_written[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 1x1 with special values, then a 2x2
    reg_write(32'd1);
    send(1'b0, 64'h3FF0_0000_0000_0000);
    send(1'b1, 64'h8000_0000_0000_0000);   // negative zero skipped
    send(1'b1, 64'h0);
    send(1'b1, 64'h7FF8_0000_0000_0001);   // NaN not skipped
    send(1'b1, 64'h7FF0_0000_0000_0000);
    send(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send(1'b0, 64'h0000_0000_0000_0001);
    send(1'b1, 64'h7FEF_FFFF_FFFF_FFFF);
    send(1'b1, 64'h3CB0_0000_0000_0000);
    send(1'b0, 64'h7FEF_FFFF_FFFF_FFFF);
    send(1'b1, 64'h7FEF_FFFF_FFFF_FFFF);   // overflow to infinity
    drain();
    reg_write(32'd2);
    send(1'b0, 64'h4000_0000_0000_0000);
    send(1'b0, 64'hC008_0000_0000_0000);
    for (int i = 0; i < 4; i++) send(1'b1, 64'h3FF0_0000_0000_0000 + i);
    send(1'b1, 64'h0);
    send(1'b1, 64'h8000_0000_0000_0000);
    drain();

    // random phases
    for (int ph = 0; ph < 24; ph++) begin
      n = ($urandom_range(5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      quiet = (ph >= 12 && ph < 16);
      reg_write(32'(n));
      load_vector();
      rows = $urandom_range(1, 5);
      if (ph == 6) hold_req = 400;
      for (int i = 0; i < rows * n; i++) begin
        if ($urandom_range(19) == 0) send(1'b0, rand_fp());
        send_mat(70);
      end
      // sometimes stop mid-row so a smaller size wraps the counters
      if ($urandom_range(3) == 0)
        for (int i = $urandom_range(1, 4); i > 0; i--) send_mat(70);
      if (ph == 20) begin
        hold_req = 500;
        for (int i = 0; i < 10 * n; i++) send_mat(30);
      end
      drain();
    end

    // sizes above the limit act as the limit; the row is left open so the
    // shrink below wraps the column counter
    reg_write(32'd2047);
    for (int i = 0; i < 40; i++) send(1'b0, rand_fp());
    for (int i = 0; i < 40; i++) send_mat(50);
    drain();

    // size zero acts as one
    reg_write(32'd0);
    send(1'b0, rand_fp());
    for (int i = 0; i < 6; i++) send_mat(80);
    drain();

    repeat (40) @(posedge clk_i);
    if (errors == 0 && row_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
